// ===== rtl/rv32ie_pkg.sv =====
// Package for the RV32IM integer execute unit.
// Holds the command codes, the divider depth and the pipeline stage record.
// No dependencies.
package rv32ie_pkg;

	localparam int NDIV = 32;

	typedef enum logic [4:0] {
		CMD_ADD    = 5'd0,
		CMD_SUB    = 5'd1,
		CMD_SLL    = 5'd2,
		CMD_SLT    = 5'd3,
		CMD_SLTU   = 5'd4,
		CMD_XOR    = 5'd5,
		CMD_SRL    = 5'd6,
		CMD_SRA    = 5'd7,
		CMD_OR     = 5'd8,
		CMD_AND    = 5'd9,
		CMD_MUL    = 5'd10,
		CMD_MULH   = 5'd11,
		CMD_MULHSU = 5'd12,
		CMD_MULHU  = 5'd13,
		CMD_DIV    = 5'd14,
		CMD_DIVU   = 5'd15,
		CMD_REM    = 5'd16,
		CMD_REMU   = 5'd17,
		CMD_BEQ    = 5'd18,
		CMD_BNE    = 5'd19,
		CMD_BLT    = 5'd20,
		CMD_BGE    = 5'd21,
		CMD_BLTU   = 5'd22,
		CMD_BGEU   = 5'd23
	} cmd_t;

	typedef struct packed {
		logic [4:0]  cmd;
		logic [31:0] other;
		logic        taken;
		logic        neg_q;
		logic        neg_r;
		logic [32:0] rem;
		logic [31:0] quo;
		logic [31:0] dvs;
	} stage_t;

endpackage

// ===== rtl/rv32im_integer_execute_unit_top.sv =====
// Top level of the RV32IM integer execute unit: ALU, multiplier, divider, branch compares.
// Depends on rv32ie_pkg for command codes and the stage record.
//
// Channel  Ports                              Handshake
// input    command, operand_a, operand_b      start high and busy low
// output   result, branch_taken               done high for one cycle
//
// One item may enter every cycle; busy is always low.
// The pipeline depth is set by the divider: one quotient bit per stage over 32 stages,
// plus an input stage, a prepare and multiply stage and an output register.
// All operations travel the same path, so results leave in order.
// Reset clears the valid bits only.
module rv32im_integer_execute_unit_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [4:0]  command,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	output logic        done,
	output logic [31:0] result,
	output logic        branch_taken
);
	import rv32ie_pkg::*;

	logic        valid_s1;
	logic [4:0]  cmd_s1;
	logic [31:0] a_s1;
	logic [31:0] b_s1;

	logic [63:0] prod_s2;
	logic [31:0] a_s2;
	logic [31:0] b_s2;

	logic        dvalid_s [0:NDIV];
	stage_t      dstg_s [0:NDIV];
	stage_t      prep;
	logic [63:0] prod;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= command;
		a_s1   <= operand_a;
		b_s1   <= operand_b;
	end

	always_comb begin
		logic        slt;
		logic        ult;
		logic        sa;
		logic        sb;
		logic [4:0]  sh;
		sa    = a_s1[31];
		sb    = b_s1[31];
		sh    = b_s1[4:0];
		slt   = (a_s1 ^ 32'h8000_0000) < (b_s1 ^ 32'h8000_0000);
		ult   = a_s1 < b_s1;
		prep        = '0;
		prep.cmd    = cmd_s1;
		case (cmd_s1)
			CMD_ADD:  prep.other = a_s1 + b_s1;
			CMD_SUB:  prep.other = a_s1 - b_s1;
			CMD_SLL:  prep.other = a_s1 << sh;
			CMD_SLT:  prep.other = {31'd0, slt};
			CMD_SLTU: prep.other = {31'd0, ult};
			CMD_XOR:  prep.other = a_s1 ^ b_s1;
			CMD_SRL:  prep.other = a_s1 >> sh;
			CMD_SRA:  prep.other = 32'($signed(a_s1) >>> sh);
			CMD_OR:   prep.other = a_s1 | b_s1;
			CMD_AND:  prep.other = a_s1 & b_s1;
			CMD_BEQ:  prep.taken = (a_s1 == b_s1);
			CMD_BNE:  prep.taken = (a_s1 != b_s1);
			CMD_BLT:  prep.taken = slt;
			CMD_BGE:  prep.taken = !slt;
			CMD_BLTU: prep.taken = ult;
			CMD_BGEU: prep.taken = !ult;
			default:  prep.other = '0;
		endcase
		if (cmd_s1 == CMD_DIV || cmd_s1 == CMD_REM) begin
			prep.quo   = sa ? (~a_s1 + 32'd1) : a_s1;
			prep.dvs   = sb ? (~b_s1 + 32'd1) : b_s1;
			prep.neg_q = (sa ^ sb) && (b_s1 != 32'd0);
			prep.neg_r = sa;
		end else begin
			prep.quo = a_s1;
			prep.dvs = b_s1;
		end
		prod = {32'd0, a_s1} * {32'd0, b_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvalid_s[0] <= 1'b0;
		end else begin
			dvalid_s[0] <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		dstg_s[0] <= prep;
		prod_s2   <= prod;
		a_s2      <= a_s1;
		b_s2      <= b_s1;
	end

	for (genvar i = 0; i < NDIV; i++) begin : g_div
		stage_t      nxt;
		logic [32:0] shifted;
		logic [32:0] diff;

		always_comb begin
			nxt     = dstg_s[i];
			shifted = {dstg_s[i].rem[31:0], dstg_s[i].quo[31]};
			diff    = shifted - {1'b0, dstg_s[i].dvs};
			if (!diff[32]) begin
				nxt.rem = diff;
				nxt.quo = {dstg_s[i].quo[30:0], 1'b1};
			end else begin
				nxt.rem = shifted;
				nxt.quo = {dstg_s[i].quo[30:0], 1'b0};
			end
			if (i == 0) begin
				case (dstg_s[i].cmd)
					CMD_MUL:    nxt.other = prod_s2[31:0];
					CMD_MULH:   nxt.other = prod_s2[63:32]
						- (a_s2[31] ? b_s2 : 32'd0) - (b_s2[31] ? a_s2 : 32'd0);
					CMD_MULHSU: nxt.other = prod_s2[63:32] - (a_s2[31] ? b_s2 : 32'd0);
					CMD_MULHU:  nxt.other = prod_s2[63:32];
					default:    nxt.other = dstg_s[i].other;
				endcase
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvalid_s[i+1] <= 1'b0;
			end else begin
				dvalid_s[i+1] <= dvalid_s[i];
			end
		end

		always_ff @(posedge clk) begin
			dstg_s[i+1] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dvalid_s[NDIV];
		end
	end

	always_ff @(posedge clk) begin
		branch_taken <= dstg_s[NDIV].taken;
		case (dstg_s[NDIV].cmd)
			CMD_DIV, CMD_DIVU: result <= dstg_s[NDIV].neg_q
				? (~dstg_s[NDIV].quo + 32'd1) : dstg_s[NDIV].quo;
			CMD_REM, CMD_REMU: result <= dstg_s[NDIV].neg_r
				? (~dstg_s[NDIV].rem[31:0] + 32'd1) : dstg_s[NDIV].rem[31:0];
			default:           result <= dstg_s[NDIV].other;
		endcase
	end

endmodule

// ===== test/rv32im_integer_execute_unit_top_tb.sv =====
// Self-checking testbench for the RV32IM integer execute unit top level.
// Drives directed and random items, predicts each result and checks it in order.
// Depends on rv32ie_pkg and rv32im_integer_execute_unit_top.
module rv32im_integer_execute_unit_top_tb;
	import rv32ie_pkg::*;

	class alu_scoreboard;
		logic [31:0] want_result[$];
		logic        want_taken[$];
		int          errors;

		static function logic [31:0] mul_high(logic [31:0] a, logic [31:0] b, bit sa, bit sb);
			logic signed [65:0] x;
			logic signed [65:0] y;
			logic signed [65:0] p;
			x = sa ? {{34{a[31]}}, a} : {34'd0, a};
			y = sb ? {{34{b[31]}}, b} : {34'd0, b};
			p = x * y;
			return p[63:32];
		endfunction

		function void note_item(logic [4:0] cmd, logic [31:0] a, logic [31:0] b);
			logic [31:0] r;
			logic        t;
			logic [4:0]  sh;
			r = '0;
			t = 1'b0;
			sh = b[4:0];
			case (cmd)
				CMD_ADD:    r = a + b;
				CMD_SUB:    r = a - b;
				CMD_SLL:    r = a << sh;
				CMD_SLT:    r = {31'd0, $signed(a) < $signed(b)};
				CMD_SLTU:   r = {31'd0, a < b};
				CMD_XOR:    r = a ^ b;
				CMD_SRL:    r = a >> sh;
				CMD_SRA:    r = $signed(a) >>> sh;
				CMD_OR:     r = a | b;
				CMD_AND:    r = a & b;
				CMD_MUL:    r = a * b;
				CMD_MULH:   r = mul_high(a, b, 1, 1);
				CMD_MULHSU: r = mul_high(a, b, 1, 0);
				CMD_MULHU:  r = mul_high(a, b, 0, 0);
				CMD_DIV: begin
					if (b == 0) r = 32'hffffffff;
					else if (a == 32'h80000000 && b == 32'hffffffff) r = a;
					else r = $signed(a) / $signed(b);
				end
				CMD_DIVU:   r = (b == 0) ? 32'hffffffff : a / b;
				CMD_REM: begin
					if (b == 0) r = a;
					else if (a == 32'h80000000 && b == 32'hffffffff) r = '0;
					else r = $signed(a) % $signed(b);
				end
				CMD_REMU:   r = (b == 0) ? a : a % b;
				CMD_BEQ:    t = (a == b);
				CMD_BNE:    t = (a != b);
				CMD_BLT:    t = $signed(a) < $signed(b);
				CMD_BGE:    t = $signed(a) >= $signed(b);
				CMD_BLTU:   t = a < b;
				CMD_BGEU:   t = a >= b;
				default: ;
			endcase
			want_result.push_back(r);
			want_taken.push_back(t);
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		task check_result(logic [31:0] r, logic t);
			logic [31:0] er;
			logic        et;
			if (want_result.size() == 0) begin
				report($sformatf("unexpected result %h", r));
				return;
			end
			er = want_result.pop_front();
			et = want_taken.pop_front();
			if (r !== er) report($sformatf("result %h, wanted %h", r, er));
			if (t !== et) report($sformatf("branch_taken %b, wanted %b", t, et));
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic [4:0]  command = '0;
	logic [31:0] operand_a = '0;
	logic [31:0] operand_b = '0;
	logic        busy;
	logic        done;
	logic [31:0] result;
	logic        branch_taken;
	int          idle_pct = 0;
	alu_scoreboard board = new();

	rv32im_integer_execute_unit_top uut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) board.check_result(result, branch_taken);
	end

	function logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hffffffff;
			2: return 32'h80000000;
			3: return 32'h7fffffff;
			4: return $urandom_range(0, 40);
			5: return -$urandom_range(1, 40);
			default: return $urandom;
		endcase
	endfunction

	task send_item(logic [4:0] cmd, logic [31:0] a, logic [31:0] b);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_item(cmd, a, b);
	endtask

	task wait_drain();
		start <= 1'b0;
		@(posedge clk);
		while (board.want_result.size() != 0) @(posedge clk);
	endtask

	initial begin
		logic [31:0] edge_vals[4];
		edge_vals = '{32'h0, 32'hffffffff, 32'h80000000, 32'h7fffffff};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int c = 0; c < 24; c++) send_item(c[4:0], edge_vals[c % 4], edge_vals[(c + 1) % 4]);
		send_item(CMD_DIV, 32'h80000000, 32'hffffffff);
		send_item(CMD_REM, 32'h80000000, 32'hffffffff);
		send_item(CMD_DIVU, 32'h12345678, 32'h0);
		send_item(CMD_REM, 32'h87654321, 32'h0);
		send_item(5'd31, 32'hffffffff, 32'hffffffff);
		wait_drain();
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 28 : (phase == 1) ? 75 : 0;
			for (int i = 0; i < 600; i++) begin
				logic [4:0] c;
				c = ($urandom_range(0, 30) == 0) ? 5'($urandom_range(24, 31))
					: 5'($urandom_range(0, 23));
				send_item(c, pick_operand(), pick_operand());
			end
			wait_drain();
		end
		repeat (40) @(posedge clk);
		if (board.errors == 0 && board.want_result.size() == 0)
			$display("PASS rv32im_integer_execute_unit_top");
		else
			$display("FAIL rv32im_integer_execute_unit_top");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL rv32im_integer_execute_unit_top");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/rv32ie_pkg.sv
rtl/rv32im_integer_execute_unit_top.sv
test/rv32im_integer_execute_unit_top_tb.sv
